>>> rtl/core/modexp_pkg.sv
`default_nettype none
package modexp_pkg;

  // Configuration register indexes.
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_MODULUS  = 2'd0;
  localparam reg_idx_t REG_EXPONENT = 2'd1;

  localparam logic [31:0] RESET_MODULUS  = 32'd1000000007;
  localparam logic [31:0] RESET_EXPONENT = 32'd1000000005;

  // Microprogram addresses.
  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_REDUCE = 3'd1;
  localparam step_t STEP_ZERO   = 3'd2;
  localparam step_t STEP_EVEN   = 3'd3;
  localparam step_t STEP_MULT   = 3'd4;
  localparam step_t STEP_SQUARE = 3'd5;
  localparam step_t STEP_FINISH = 3'd6;

  // Exponent register operations.
  typedef logic [1:0] exp_op_t;
  localparam exp_op_t EXP_HOLD = 2'd0;
  localparam exp_op_t EXP_DEC  = 2'd1;
  localparam exp_op_t EXP_SHR  = 2'd2;

  // Sequencer branch conditions.
  typedef logic [2:0] cond_t;
  localparam cond_t COND_NEXT   = 3'd0;
  localparam cond_t COND_ALWAYS = 3'd1;
  localparam cond_t COND_EZERO  = 3'd2;
  localparam cond_t COND_EEVEN  = 3'd3;
  localparam cond_t COND_START  = 3'd4;

  typedef struct packed {
    logic    mul_go;    // run the modular multiplier, wait for it
    logic    opa_base;  // multiplicand: 1 = running base, 0 = constant one
    logic    opb_base;  // multiplier: 1 = running base, 0 = accumulator
    logic    dst_acc;   // product goes to: 1 = accumulator, 0 = running base
    exp_op_t exp_op;
    cond_t   cond;
    step_t   target;
    logic    emit;      // present the result item
  } cw_t;

  function automatic cw_t ucode(step_t pc);
    cw_t cw;
    cw = '{mul_go: 1'b0, opa_base: 1'b0, opb_base: 1'b0, dst_acc: 1'b0,
           exp_op: EXP_HOLD, cond: COND_START, target: STEP_REDUCE, emit: 1'b0};
    unique case (pc)
      STEP_IDLE: begin
        cw.cond   = COND_START;
        cw.target = STEP_REDUCE;
      end
      STEP_REDUCE: begin
        // base * 1 mod m brings the raw base below the modulus.
        cw.mul_go   = 1'b1;
        cw.opa_base = 1'b0;
        cw.opb_base = 1'b1;
        cw.dst_acc  = 1'b0;
        cw.cond     = COND_NEXT;
      end
      STEP_ZERO: begin
        cw.cond   = COND_EZERO;
        cw.target = STEP_FINISH;
      end
      STEP_EVEN: begin
        cw.cond   = COND_EEVEN;
        cw.target = STEP_SQUARE;
      end
      STEP_MULT: begin
        cw.mul_go   = 1'b1;
        cw.opa_base = 1'b1;
        cw.opb_base = 1'b0;
        cw.dst_acc  = 1'b1;
        cw.exp_op   = EXP_DEC;
        cw.cond     = COND_ALWAYS;
        cw.target   = STEP_ZERO;
      end
      STEP_SQUARE: begin
        cw.mul_go   = 1'b1;
        cw.opa_base = 1'b1;
        cw.opb_base = 1'b1;
        cw.dst_acc  = 1'b0;
        cw.exp_op   = EXP_SHR;
        cw.cond     = COND_ALWAYS;
        cw.target   = STEP_ZERO;
      end
      STEP_FINISH: begin
        cw.emit   = 1'b1;
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_IDLE;
      end
      default: begin
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/modexp_mulmod.sv
`default_nettype none
module modexp_mulmod #(
  parameter int VALUE_WIDTH = 31
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   go,
  input  wire logic [VALUE_WIDTH-1:0] a,
  input  wire logic [VALUE_WIDTH-1:0] b,
  input  wire logic [VALUE_WIDTH-1:0] m,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      prod
);

  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam int SUM_W = VALUE_WIDTH + 2;

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic [VALUE_WIDTH-1:0] a_r, a_nxt;
  logic [VALUE_WIDTH-1:0] mpl_r, mpl_nxt;
  logic [SUM_W-1:0]       m_ext, sum, sub1, sub2;

  // Interleaved multiply-reduce, multiplier MSB first. The multiplicand must
  // be below m, so the accumulator stays below m and 2*acc + a stays below 3m.
  always_comb begin
    m_ext = {2'b00, m};
    sum   = {1'b0, acc_r, 1'b0}
          + {2'b00, a_r & {VALUE_WIDTH{mpl_r[VALUE_WIDTH-1]}}};
    sub1  = (sum >= m_ext) ? sum - m_ext : sum;
    sub2  = (sub1 >= m_ext) ? sub1 - m_ext : sub1;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    mpl_nxt  = mpl_r;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(VALUE_WIDTH - 1);
      acc_nxt  = '0;
      a_nxt    = a;
      mpl_nxt  = b;
    end else if (busy_r) begin
      acc_nxt = sub2[VALUE_WIDTH-1:0];
      mpl_nxt = {mpl_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    mpl_r <= mpl_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

`ifndef SYNTHESIS
  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> !busy_r)
    else $error("multiply started while the unit is busy");
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !go && cnt_r == '0 |=> done_r && !busy_r)
    else $error("multiply did not finish after its last bit");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && !$past(done_r))
    else $error("done pulse overlaps a running multiply");
`endif

endmodule
`default_nettype wire

>>> rtl/core/modular_exponentiation_top.sv
`default_nettype none
// Channel     Ports                              Handshake
// input       start, busy, in_base               taken when start && !busy
// result      out_valid, out_result              one-cycle strobe, no stall
// config      cfg_we, cfg_index, cfg_data        written when cfg_we is high
//
// The bit-serial modular multiplier sets how long an item takes, one
// multiplier bit per cycle; each item runs one multiply or squaring per
// loop pass, up to twice EXP_WIDTH of them, after its base reduction.
// Reset is synchronous and loads the modulus 1000000007 and exponent
// 1000000005. The result strobe cannot be held off by the receiver.
module modular_exponentiation_top #(
  parameter int VALUE_WIDTH = 31,
  parameter int EXP_WIDTH   = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [VALUE_WIDTH-1:0]   in_base,
  output logic                          out_valid,
  output logic [VALUE_WIDTH-1:0]        out_result,
  input  wire logic                     cfg_we,
  input  wire modexp_pkg::reg_idx_t     cfg_index,
  input  wire logic [(VALUE_WIDTH > EXP_WIDTH ? VALUE_WIDTH : EXP_WIDTH)-1:0] cfg_data
);
  import modexp_pkg::*;

  logic [VALUE_WIDTH-1:0] modulus_r, modulus_nxt;
  logic [EXP_WIDTH-1:0]   expcfg_r, expcfg_nxt;
  logic [EXP_WIDTH-1:0]   exp_r, exp_nxt;
  logic [VALUE_WIDTH-1:0] base_r, base_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  step_t                  pc_r, pc_nxt;
  logic                   issued_r, issued_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0] out_result_r, out_result_nxt;

  cw_t                    cw;
  logic                   in_accept;
  logic                   mul_go, mul_done, step_done;
  logic [VALUE_WIDTH-1:0] mul_a, mul_b, mul_prod;
  step_t                  pc_inc;

  assign in_accept = start && !busy;
  assign busy      = (pc_r != STEP_IDLE);

  always_comb begin
    cw        = ucode(pc_r);
    mul_go    = cw.mul_go && !issued_r;
    step_done = !cw.mul_go || mul_done;
    mul_a     = cw.opa_base ? base_r : VALUE_WIDTH'(1);
    mul_b     = cw.opb_base ? base_r : acc_r;
    pc_inc    = pc_r + 1'b1;
  end

  modexp_mulmod #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_mulmod (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .m    (modulus_r),
    .done (mul_done),
    .prod (mul_prod)
  );

  // Sequencer: a step that runs the multiplier holds until its product is in.
  always_comb begin
    pc_nxt = pc_r;
    if (step_done) begin
      unique case (cw.cond)
        COND_NEXT:   pc_nxt = pc_inc;
        COND_ALWAYS: pc_nxt = cw.target;
        COND_EZERO:  pc_nxt = (exp_r == '0) ? cw.target : pc_inc;
        COND_EEVEN:  pc_nxt = !exp_r[0] ? cw.target : pc_inc;
        COND_START:  pc_nxt = start ? cw.target : pc_r;
        default:     pc_nxt = STEP_IDLE;
      endcase
    end
  end

  always_comb begin
    issued_nxt     = issued_r;
    exp_nxt        = exp_r;
    base_nxt       = base_r;
    acc_nxt        = acc_r;
    modulus_nxt    = modulus_r;
    expcfg_nxt     = expcfg_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS:  modulus_nxt = cfg_data[VALUE_WIDTH-1:0];
        REG_EXPONENT: expcfg_nxt  = cfg_data[EXP_WIDTH-1:0];
        default: ;
      endcase
    end

    if (in_accept) begin
      base_nxt = in_base;
      acc_nxt  = VALUE_WIDTH'(1);
      exp_nxt  = expcfg_r;
    end

    if (mul_go) begin
      issued_nxt = 1'b1;
    end

    if (cw.mul_go && mul_done) begin
      issued_nxt = 1'b0;
      if (cw.dst_acc) begin
        acc_nxt = mul_prod;
      end else begin
        base_nxt = mul_prod;
      end
      unique case (cw.exp_op)
        EXP_HOLD: exp_nxt = exp_r;
        EXP_DEC:  exp_nxt = {exp_r[EXP_WIDTH-1:1], 1'b0};
        EXP_SHR:  exp_nxt = {1'b0, exp_r[EXP_WIDTH-1:1]};
        default:  exp_nxt = exp_r;
      endcase
    end

    // A modulus of zero or one answers zero.
    if (cw.emit) begin
      out_valid_nxt  = 1'b1;
      out_result_nxt = (modulus_r < VALUE_WIDTH'(2)) ? '0 : acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      modulus_r   <= RESET_MODULUS[VALUE_WIDTH-1:0];
      expcfg_r    <= RESET_EXPONENT[EXP_WIDTH-1:0];
    end else begin
      pc_r        <= pc_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      modulus_r   <= modulus_nxt;
      expcfg_r    <= expcfg_nxt;
    end
    exp_r        <= exp_nxt;
    base_r       <= base_nxt;
    acc_r        <= acc_nxt;
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

`ifndef SYNTHESIS
  a_accept_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> pc_r == STEP_REDUCE && !issued_r)
    else $error("accepted item did not enter the base reduction");
  a_strobe_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(pc_r) == STEP_FINISH && pc_r == STEP_IDLE)
    else $error("result strobe without a finish step");
  a_issue_mul_step: assert property (@(posedge clk) disable iff (!rst_n)
    issued_r |-> cw.mul_go)
    else $error("multiply outstanding outside a multiply step");
`endif

endmodule
`default_nettype wire
